/* hdl/b2h_pkg.sv */
// Package for the binary64 to binary16 pair packer.
// Holds half-format constants, the front-to-back queue entry type and the conversion function.
// No dependencies.
`timescale 1ns / 1ps
package b2h_pkg;
    localparam logic [15:0] HALF_SIGN = 16'h8000;
    localparam logic [15:0] HALF_INF  = 16'h7c00;
    localparam int          Q_DEPTH   = 2;

    // classified, converted item handed from front to back
    typedef struct packed {
        logic [15:0] half;
    } t_entry;

    // round-to-nearest-even conversion of one binary64 pattern
    function automatic logic [15:0] to_half(input logic [63:0] bits);
        logic [15:0] sgn;
        logic [10:0] bexp;
        logic [51:0] frac;
        logic [52:0] sig;
        logic [11:0] sh;
        logic [52:0] q;
        logic [52:0] rem;
        logic [52:0] hlf;
        logic [52:0] msk;
        logic        up;
        logic [11:0] r;
        logic [15:0] res;
        sgn  = bits[63] ? HALF_SIGN : 16'h0000;
        bexp = bits[62:52];
        frac = bits[51:0];
        sig  = {1'b1, frac};
        sh   = 12'd0;
        q    = '0;
        rem  = '0;
        hlf  = '0;
        msk  = '0;
        up   = 1'b0;
        r    = '0;
        res  = '0;
        if (bexp == 11'h7ff) begin
            res = (frac != '0) ? 16'h0000 : (sgn | HALF_INF);
        end else if (bexp == 11'd0) begin
            // zero gives +0, binary64 subnormals are far below half range
            res = (frac == '0) ? 16'h0000 : sgn;
        end else if (bexp > 11'd1038) begin
            res = sgn | HALF_INF;
        end else if (bexp >= 11'd1009) begin
            // normal half range: drop 42 fraction bits, half exponent = bexp - 1008
            q   = sig >> 42;
            rem = sig & 53'h3ff_ffff_ffff;
            up  = (rem > 53'h200_0000_0000) || (rem == 53'h200_0000_0000 && q[0]);
            r   = q[11:0] + {11'd0, up};
            if (r[11]) begin
                if (bexp == 11'd1038) res = sgn | HALF_INF;
                else res = sgn | {1'b0, bexp[4:0] - 5'd16 + 5'd1, 10'd0};
            end else begin
                res = sgn | {1'b0, bexp[4:0] - 5'd16, r[9:0]};
            end
        end else begin
            // subnormal half: shift = 28 - e = 1051 - bexp
            sh = 12'd1051 - {1'b0, bexp};
            if (sh > 12'd53) begin
                // whole significand lies below half a quantum
                res = sgn;
            end else begin
                q   = sig >> sh[5:0];
                msk = (53'd1 << sh[5:0]) - 53'd1;
                rem = sig & msk;
                hlf = 53'd1 << (sh[5:0] - 6'd1);
                up  = (rem > hlf) || (rem == hlf && q[0]);
                r   = q[11:0] + {11'd0, up};
                res = sgn | {5'd0, r[10:0]};
            end
        end
        return res;
    endfunction
endpackage

/* hdl/b2h_front.sv */
// Front part: accepts binary64 items, converts them to halves and registers the result.
// Depends on b2h_pkg.
`timescale 1ns / 1ps
module b2h_front import b2h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output t_entry      o_entry
);
    logic   r_valid;
    t_entry r_entry;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    // conversion stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_entry.half <= to_half(i_bits);
        end
    end
endmodule

/* hdl/b2h_queue.sv */
// Two-entry queue between front and back parts.
// Depends on b2h_pkg.
`timescale 1ns / 1ps
module b2h_queue import b2h_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_entry i_entry,
    output logic   o_valid,
    input  logic   i_ready,
    output t_entry o_entry
);
    t_entry     r_mem [Q_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = r_cnt != 2'(Q_DEPTH);
    assign o_valid = r_cnt != 2'd0;
    assign o_entry = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_entry;
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(Q_DEPTH)) else $error("queue overfilled");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(Q_DEPTH)) |-> !o_ready) else $error("ready while full");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_valid) else $error("valid while empty");
endmodule

/* hdl/b2h_back.sv */
// Back part: pairs halves and drives the 32-bit output register.
// Depends on b2h_pkg.
`timescale 1ns / 1ps
module b2h_back import b2h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_entry      i_entry,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_word
);
    logic        r_phase;
    logic [15:0] r_pend;
    logic        r_valid;
    logic [31:0] r_word;
    logic        w_take;

    assign o_ready = r_phase == 1'b0 || !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // pairing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_valid && !i_ready) || (w_take && r_phase);
            if (w_take) r_phase <= !r_phase;
        end
        if (w_take && !r_phase) r_pend <= i_entry.half;
        if (w_take && r_phase)  r_word <= {i_entry.half, r_pend};
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> r_valid && $stable(r_word)) else $error("output lost");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_phase) |=> r_valid) else $error("pair not emitted");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !r_phase && !r_valid) |=> !r_valid) else $error("spurious output");
endmodule

/* hdl/binary64_to_half_pair_packer.sv */
// Top level of the binary64 to binary16 pair packer.
// Depends on b2h_pkg, b2h_front, b2h_queue, b2h_back.
//
// channel | direction | tdata fields (low bit up)
// s_axis  | in        | value_bits[63:0]
// m_axis  | out       | packed_word[31:0]
//
// One item accepted per cycle while the output does not stall; a word leaves after every second item.
// Items pass through the convert register, the queue and the output register.
// Synchronous active-low reset drops any held first half.
// Output stalls fill the queue, then backpressure the input.
`timescale 1ns / 1ps
module binary64_to_half_pair_packer import b2h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // packed_word
);
    logic   f_valid, f_ready, b_valid, b_ready;
    t_entry f_entry, b_entry;

    b2h_front u_front (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_bits(s_axis_tdata), .o_valid(f_valid), .i_ready(f_ready), .o_entry(f_entry));
    b2h_queue u_queue (.i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready),
        .i_entry(f_entry), .o_valid(b_valid), .i_ready(b_ready), .o_entry(b_entry));
    b2h_back u_back (.i_clk, .i_rst_n, .i_valid(b_valid), .o_ready(b_ready),
        .i_entry(b_entry), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(m_axis_tdata));
endmodule

/* bench/binary64_to_half_pair_packer_test.sv */
// Testbench for the binary64 to binary16 pair packer.
// Drives binary64 patterns, predicts packed half pairs and checks each output word.
// Depends on binary64_to_half_pair_packer and b2h_pkg.
`timescale 1ns / 1ps
module binary64_to_half_pair_packer_test;
    import b2h_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // value_bits
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // packed_word

    binary64_to_half_pair_packer dut (.*);

    always #5 i_clk = ~i_clk;

    // exact round-to-nearest-even right shift, s in 1..63
    function automatic logic [63:0] rne_shift(input logic [63:0] sig, input int s);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] hlf;
        q   = sig >> s;
        rem = sig & ((64'd1 << s) - 64'd1);
        hlf = 64'd1 << (s - 1);
        if (rem > hlf || (rem == hlf && q[0])) q = q + 64'd1;
        return q;
    endfunction

    function automatic logic [15:0] predict_half(input logic [63:0] v);
        logic [15:0] sgn;
        logic [10:0] bexp;
        logic [63:0] sig;
        logic [63:0] r;
        int          e;
        sgn  = v[63] ? HALF_SIGN : 16'h0000;
        bexp = v[62:52];
        if (bexp == 11'h7ff) return (v[51:0] != '0) ? 16'h0000 : (sgn | HALF_INF);
        if (bexp == 0 && v[51:0] == '0) return 16'h0000;
        if (bexp == 0) begin
            sig = {12'd0, v[51:0]};
            e = -1022;
        end else begin
            sig = {11'd0, 1'b1, v[51:0]};
            e = int'(bexp) - 1023;
        end
        if (e > 15) return sgn | HALF_INF;
        if (e >= -14) begin
            r = rne_shift(sig, 42);
            if (r >= 64'd2048) begin
                e = e + 1;
                if (e > 15) return sgn | HALF_INF;
                r = 64'd1024;
            end
            return sgn | 16'((e + 15) << 10) | 16'(r - 64'd1024);
        end
        if (28 - e > 60) return sgn;
        r = rne_shift(sig, 28 - e);
        return sgn | r[15:0];
    endfunction

    class pair_scoreboard;
        logic [31:0] word_q[$];
        logic [15:0] held_half;
        bit          have_low;
        int          errors;

        function void note_value(logic [63:0] v);
            logic [15:0] h;
            h = predict_half(v);
            if (!have_low) begin
                held_half = h;
                have_low = 1;
            end else begin
                word_q.push_back({h, held_half});
                have_low = 0;
            end
        endfunction

        function void check_word(logic [31:0] w);
            logic [31:0] exp_w;
            if (word_q.size() == 0) begin
                $display("%0t: unexpected word actual %h", $time, w);
                errors++;
                return;
            end
            exp_w = word_q.pop_front();
            if (exp_w !== w) begin
                $display("%0t: packed_word expected %h actual %h", $time, exp_w, w);
                errors++;
            end
        endfunction
    endclass

    pair_scoreboard sb = new();
    bit   recv_stall_enable = 1;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // valid stays high across back-to-back transactions
    task automatic send_value(input logic [63:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_value(v);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        int          p;
        v = {$urandom, $urandom};
        p = $urandom_range(0, 9);
        // bias exponent toward the interesting half range
        if (p < 5) v[62:52] = 11'(1023 + $urandom_range(0, 45) - 30);
        else if (p == 5) v[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h000;
        else if (p == 6) v[41:0] = $urandom_range(0, 1) ? 42'h200_0000_0000 : 42'h0;
        return v;
    endfunction

    // receiver with random backpressure, or always ready while stalls are disabled
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
        if (!recv_stall_enable) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    initial begin
        #2000000;
        $display("binary64_to_half_pair_packer_test: errors");
        $finish;
    end

    initial begin
        logic [63:0] directed[$];
        directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                     64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
                     64'h7ff8_0000_0000_0000, 64'hfff0_0000_0000_0001,
                     64'h40ef_fc00_0000_0000, 64'h40ef_fe00_0000_0000,
                     64'hc0ef_fdff_ffff_ffff, 64'h40f0_0000_0000_0000,
                     64'h3f10_0000_0000_0000, 64'h3f0f_f800_0000_0000,
                     64'h3e70_0000_0000_0000, 64'h3e60_0000_0000_0001,
                     64'h3e60_0000_0000_0000, 64'hbe50_0000_0000_0000,
                     64'h0000_0000_0000_0001, 64'h800f_ffff_ffff_ffff,
                     64'h3ff0_0200_0000_0000, 64'h3ff0_0600_0000_0000,
                     64'hffff_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000,
                     64'h7fef_ffff_ffff_ffff};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) send_value(directed[i]);
        for (int n = 0; n < 1900; n++) begin
            if (n == 900) begin
                // hold off until the pipeline drains; also run without stalls
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.word_q.size() != 0) @(posedge i_clk);
                recv_stall_enable = 0;
            end
            if (n == 1300) recv_stall_enable = 1;
            send_value(rand_value());
        end
        s_axis_tvalid <= 1'b0;
        while (sb.word_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.word_q.size() == 0)
            $display("binary64_to_half_pair_packer_test: clean");
        else
            $display("binary64_to_half_pair_packer_test: errors");
        $finish;
    end
endmodule

/* sim.f */
hdl/b2h_pkg.sv
hdl/b2h_front.sv
hdl/b2h_queue.sv
hdl/b2h_back.sv
hdl/binary64_to_half_pair_packer.sv
bench/binary64_to_half_pair_packer_test.sv
